@@ hdl/modexp_pkg.sv @@
`timescale 1ns / 1ps

package modexp_pkg;

  // Arithmetic width of base, modulus and every intermediate residue
  localparam int OPERAND_WIDTH = 32;

  // Fixed widths of the channel fields
  localparam int FIELD_W = 32;
  localparam int EXP_W   = 63;

  // Full product and the bit counter that walks it
  localparam int PROD_W = 2 * OPERAND_WIDTH;
  localparam int CNT_W  = $clog2(PROD_W);

  typedef logic [OPERAND_WIDTH-1:0] operand_t;
  typedef logic [PROD_W-1:0]        product_t;
  typedef logic [CNT_W-1:0]         bit_cnt_t;
  typedef logic [EXP_W-1:0]         exponent_t;

  // Request to the modular multiply unit
  typedef struct packed {
    logic     start;
    operand_t a;
    operand_t b;
    operand_t m;
  } mm_req_t;

  // Response from the modular multiply unit
  typedef struct packed {
    logic     done;
    operand_t result;
  } mm_rsp_t;

endpackage

@@ hdl/modexp_if.sv @@
`timescale 1ns / 1ps

// Input channel: one base, exponent and modulus per transfer
interface modexp_in_if;
  logic                                valid;
  logic                                ready;
  logic [modexp_pkg::FIELD_W-1:0]      base_value;
  logic [modexp_pkg::EXP_W-1:0]        exponent_value;
  logic [modexp_pkg::FIELD_W-1:0]      modulus_value;

  modport source (output valid, base_value, exponent_value, modulus_value, input ready);
  modport sink   (input valid, base_value, exponent_value, modulus_value, output ready);
endinterface

// Result channel: one power per transfer
interface modexp_out_if;
  logic                           valid;
  logic                           ready;
  logic [modexp_pkg::FIELD_W-1:0] power_result;

  modport source (output valid, power_result, input ready);
  modport sink   (input valid, power_result, output ready);
endinterface

@@ hdl/modular_exponentiation.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Signals                                            Transfer
// in_ch     in   base_value[31:0] exponent_value[62:0]              valid & ready
//                modulus_value[31:0]
// out_ch    out  power_result[31:0]                                 valid & ready
//
// Each modular multiply runs in the shared unit; an item with exponent e takes
// popcount(e) + bitlength(e) multiplies, and a zero exponent or modulus takes
// none and goes straight to the done state.
// in_ch.ready is high only while the sequencer is idle; one item at a time.
// A finished result waits in the output register while the next item starts.
// Synchronous active-low reset returns to idle with no result pending.
module modular_exponentiation (
  input  logic                clk,
  input  logic                rst_n,
  modexp_in_if.sink           in_ch,
  modexp_out_if.source        out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BASE = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                      state_r, state_nxt;
  modexp_pkg::exponent_t           exp_r, exp_nxt;
  modexp_pkg::operand_t            mod_r, mod_nxt;
  modexp_pkg::operand_t            acc_r, acc_nxt;
  modexp_pkg::operand_t            sq_r, sq_nxt;
  modexp_pkg::operand_t            op_a_r, op_a_nxt;
  modexp_pkg::operand_t            op_b_r, op_b_nxt;
  logic                            start_r, start_nxt;
  logic                            out_valid_r, out_valid_nxt;
  modexp_pkg::operand_t            out_res_r, out_res_nxt;
  modexp_pkg::mm_req_t             mm_req;
  modexp_pkg::mm_rsp_t             mm_rsp;
  modexp_pkg::exponent_t           exp_shift;
  logic                            in_xfer;
  logic                            out_xfer;

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign out_xfer  = out_valid_r && out_ch.ready;
  assign exp_shift = exp_r >> 1;

  // Shared modular multiply unit
  assign mm_req.start = start_r;
  assign mm_req.a     = op_a_r;
  assign mm_req.b     = op_b_r;
  assign mm_req.m     = mod_r;

  modexp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  // Sequence the square-and-multiply over the exponent bits
  always_comb begin
    state_nxt     = state_r;
    exp_nxt       = exp_r;
    mod_nxt       = mod_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    op_a_nxt      = op_a_r;
    op_b_nxt      = op_b_r;
    start_nxt     = 1'b0;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;

    // Drop the result once transferred
    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          exp_nxt = in_ch.exponent_value;
          mod_nxt = in_ch.modulus_value[modexp_pkg::OPERAND_WIDTH-1:0];
          priority if (in_ch.exponent_value == '0) begin
            acc_nxt   = modexp_pkg::OPERAND_WIDTH'(1);
            state_nxt = S_DONE;
          end else if (in_ch.modulus_value[modexp_pkg::OPERAND_WIDTH-1:0] == '0) begin
            acc_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            // Start from 1 mod m, reduce the base by multiplying it with 1
            if (in_ch.modulus_value[modexp_pkg::OPERAND_WIDTH-1:0] ==
                modexp_pkg::OPERAND_WIDTH'(1)) begin
              acc_nxt = '0;
            end else begin
              acc_nxt = modexp_pkg::OPERAND_WIDTH'(1);
            end
            op_a_nxt  = in_ch.base_value[modexp_pkg::OPERAND_WIDTH-1:0];
            op_b_nxt  = modexp_pkg::OPERAND_WIDTH'(1);
            start_nxt = 1'b1;
            state_nxt = S_BASE;
          end
        end
      end
      S_BASE: begin
        if (mm_rsp.done) begin
          sq_nxt    = mm_rsp.result;
          start_nxt = 1'b1;
          if (exp_r[0]) begin
            op_a_nxt  = acc_r;
            op_b_nxt  = mm_rsp.result;
            state_nxt = S_ACC;
          end else begin
            op_a_nxt  = mm_rsp.result;
            op_b_nxt  = mm_rsp.result;
            state_nxt = S_SQ;
          end
        end
      end
      S_ACC: begin
        if (mm_rsp.done) begin
          acc_nxt = mm_rsp.result;
          // Skip the final square once no higher bit remains
          if (exp_shift == '0) begin
            state_nxt = S_DONE;
          end else begin
            op_a_nxt  = sq_r;
            op_b_nxt  = sq_r;
            start_nxt = 1'b1;
            state_nxt = S_SQ;
          end
        end
      end
      S_SQ: begin
        if (mm_rsp.done) begin
          sq_nxt    = mm_rsp.result;
          exp_nxt   = exp_shift;
          start_nxt = 1'b1;
          if (exp_shift[0]) begin
            op_a_nxt  = acc_r;
            op_b_nxt  = mm_rsp.result;
            state_nxt = S_ACC;
          end else begin
            op_a_nxt  = mm_rsp.result;
            op_b_nxt  = mm_rsp.result;
            state_nxt = S_SQ;
          end
        end
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_res_nxt   = acc_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    exp_r     <= exp_nxt;
    mod_r     <= mod_nxt;
    acc_r     <= acc_nxt;
    sq_r      <= sq_nxt;
    op_a_r    <= op_a_nxt;
    op_b_r    <= op_b_nxt;
    out_res_r <= out_res_nxt;
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.power_result = modexp_pkg::FIELD_W'(out_res_r);

endmodule

@@ hdl/modexp_mulmod.sv @@
`timescale 1ns / 1ps

// Modular multiply: a*b is formed into a register when start is seen, then restoring
// reduction of the product one bit per cycle, most significant bit first.
module modexp_mulmod (
  input  logic                clk,
  input  logic                rst_n,
  input  modexp_pkg::mm_req_t req,
  output modexp_pkg::mm_rsp_t rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RED  = 2'd1;

  logic [1:0]                           state_r, state_nxt;
  modexp_pkg::product_t                 prod_r, prod_nxt;
  modexp_pkg::operand_t                 rem_r, rem_nxt;
  modexp_pkg::operand_t                 mod_r, mod_nxt;
  modexp_pkg::bit_cnt_t                 cnt_r, cnt_nxt;
  logic                                 done_r, done_nxt;
  logic [modexp_pkg::OPERAND_WIDTH:0]   trial;
  logic [modexp_pkg::OPERAND_WIDTH:0]   diff;

  // Shift the next product bit into the remainder and trial-subtract
  assign trial = {rem_r, prod_r[cnt_r]};
  assign diff  = trial - {1'b0, mod_r};

  always_comb begin
    state_nxt = state_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    mod_nxt   = mod_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          prod_nxt  = modexp_pkg::PROD_W'(req.a) * modexp_pkg::PROD_W'(req.b);
          mod_nxt   = req.m;
          rem_nxt   = '0;
          cnt_nxt   = modexp_pkg::CNT_W'(modexp_pkg::PROD_W - 1);
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        if (trial >= {1'b0, mod_r}) begin
          rem_nxt = diff[modexp_pkg::OPERAND_WIDTH-1:0];
        end else begin
          rem_nxt = trial[modexp_pkg::OPERAND_WIDTH-1:0];
        end
        if (cnt_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    mod_r  <= mod_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = rem_r;

endmodule

@@ hdl/modexp_checker.sv @@
`timescale 1ns / 1ps

module modexp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [modexp_pkg::FIELD_W-1:0] power_result
);

  // Reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (in_ready && !out_valid))
    else $error("block not idle after reset");

  // One item at a time: ready drops after an input transfer
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready stayed high after a transfer");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn before transfer");

  // A stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(power_result))
    else $error("result changed while stalled");

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .power_result (out_ch.power_result)
);

@@ tb/modexp_checker.sv @@
`timescale 1ns / 1ps

module modexp_scoreboard (
  input  logic    clk,
  input  logic    rst_n,
  modexp_in_if    in_ch,
  modexp_out_if   out_ch,
  output int      fail_count,
  output int      pending_count
);

  localparam int OPERAND_WIDTH = modexp_pkg::OPERAND_WIDTH;
  localparam int FIELD_W       = modexp_pkg::FIELD_W;
  localparam int EXP_W         = modexp_pkg::EXP_W;

  // Powers predicted for accepted items, oldest first
  logic [FIELD_W-1:0] power_q [$];
  int                 mismatch_cnt = 0;

  // Square-and-multiply over the exponent, least significant bit first
  function automatic logic [FIELD_W-1:0] predict_power(input logic [FIELD_W-1:0] base_in,
                                                       input logic [EXP_W-1:0]   expo_in,
                                                       input logic [FIELD_W-1:0] mod_in);
    logic [63:0]      width_mask;
    logic [63:0]      base_r;
    logic [63:0]      mod_r;
    logic [63:0]      acc;
    logic [63:0]      square;
    logic [EXP_W-1:0] expo;
    width_mask = (64'd1 << OPERAND_WIDTH) - 64'd1;
    base_r     = {32'd0, base_in} & width_mask;
    mod_r      = {32'd0, mod_in} & width_mask;
    expo       = expo_in;
    // Zero exponent gives one, whatever the modulus
    if (expo == '0) begin
      return FIELD_W'(1);
    end
    if (mod_r == 64'd0) begin
      return '0;
    end
    square = base_r % mod_r;
    acc    = 64'd1 % mod_r;
    for (int i = 0; i < EXP_W; i++) begin
      if (expo[i]) begin
        acc = (acc * square) % mod_r;
      end
      square = (square * square) % mod_r;
    end
    return acc[FIELD_W-1:0];
  endfunction

  // Compare each result transfer first, then queue the prediction for a new input
  always @(posedge clk) begin
    logic [FIELD_W-1:0] want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (power_q.size() == 0) begin
          $error("power_result: no result expected, actual %08h", out_ch.power_result);
          mismatch_cnt++;
        end else begin
          want = power_q.pop_front();
          if (out_ch.power_result !== want) begin
            $error("power_result: expected %08h, actual %08h", want, out_ch.power_result);
            mismatch_cnt++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        power_q = {power_q, predict_power(in_ch.base_value, in_ch.exponent_value,
                                          in_ch.modulus_value)};
      end
    end
    fail_count    <= mismatch_cnt;
    pending_count <= power_q.size();
  end

endmodule

@@ tb/tb_modular_exponentiation.sv @@
`timescale 1ns / 1ps

module tb_modular_exponentiation;

  localparam int FIELD_W      = modexp_pkg::FIELD_W;
  localparam int EXP_W        = modexp_pkg::EXP_W;
  localparam int RANDOM_ITEMS = 120;
  localparam int CYCLE_LIMIT  = 6000000;
  localparam int HOLD_CYCLES  = 20000;
  localparam int TAIL_CYCLES  = 200;

  typedef enum int {RX_FREE, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_t;

  logic clk;
  logic rst_n;
  logic rx_hold_req;
  int   fail_cnt;
  int   pending_cnt;

  modexp_in_if  in_ch ();
  modexp_out_if out_ch ();

  modular_exponentiation i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  modexp_scoreboard i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_cnt),
    .pending_count (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one item and hold it until the transfer
  task automatic send_item(input logic [FIELD_W-1:0] base_v, input logic [EXP_W-1:0] expo_v,
                           input logic [FIELD_W-1:0] mod_v);
    in_ch.valid          <= 1'b1;
    in_ch.base_value     <= base_v;
    in_ch.exponent_value <= expo_v;
    in_ch.modulus_value  <= mod_v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Drop valid for a number of cycles
  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      in_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every predicted power has arrived
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
  endtask

  // Receiver: random segments of stall patterns, plus one long hold-off on request
  initial begin : rx_pattern
    int       seg_left;
    int       hold_left;
    bit       hold_done;
    rx_mode_t mode;
    seg_left     = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    mode         = RX_FREE;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_hold_req && !hold_done) begin
        hold_done    = 1'b1;
        hold_left    = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(8, 64);
          mode     = rx_mode_t'($urandom_range(0, 3));
        end
        seg_left--;
        case (mode)
          RX_FREE:   out_ch.ready <= 1'b1;
          RX_HALF:   out_ch.ready <= $urandom_range(0, 1) == 1;
          RX_MOSTLY: out_ch.ready <= $urandom_range(0, 3) != 0;
          default:   out_ch.ready <= $urandom_range(0, 5) == 0;
        endcase
      end
    end
  end

  // End the run if it never completes
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** modular_exponentiation: FAILED **");
    $finish;
  end

  // Stimulus: directed corners, then bursts of random items
  initial begin : stimulus
    logic [FIELD_W-1:0] base_v;
    logic [EXP_W-1:0]   expo_v;
    logic [FIELD_W-1:0] mod_v;
    logic [63:0]        wide;
    int                 roll;
    int                 nbits;
    int                 burst;
    int                 sent;

    rst_n                <= 1'b0;
    rx_hold_req          <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.base_value     <= '0;
    in_ch.exponent_value <= '0;
    in_ch.modulus_value  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero exponent, also with modulus one and base zero
    send_item(32'h1234_5678, '0, 32'd1);
    send_item(32'hFFFF_FFFF, '0, 32'hFFFF_FFFF);
    send_item(32'd0, '0, 32'h10);
    // Modulus one with a nonzero exponent, then base zero and a small base
    send_item(32'hDEAD_BEEF, 63'd5, 32'd1);
    send_item(32'd0, 63'd1, 32'd7);
    send_item(32'd3, 63'd1, 32'hFFFF_FFFF);
    // Base equal to the modulus reduces to zero
    send_item(32'hFFFF_FFFF, 63'd1, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, {EXP_W{1'b1}}, 32'hFFFF_FFFF);
    // Largest operands with the longest exponent
    send_item(32'hFFFF_FFFE, {EXP_W{1'b1}}, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, {EXP_W{1'b1}}, 32'hFFFF_FFFB);
    idle_gap(3);
    send_item(32'd2, 63'd1000000006, 32'd1000000007);
    send_item(32'd3, 63'h4000_0000_0000_0000, 32'd1000000007);
    send_item(32'd1, {EXP_W{1'b1}}, 32'hFFFF_FFFB);
    send_item(32'h7FFF_FFFF, 63'd3, 32'h8000_0000);
    send_item(32'hFFFF_FFFF, 63'd2, 32'h8000_0001);
    send_item(32'd5, {EXP_W{1'b1}}, 32'd2);
    send_item(32'hFFFF_FFFF, 63'h5555_5555_5555_5555, 32'hFFFF_FFFE);
    send_item(32'h89AB_CDEF, 63'h2AAA_AAAA_AAAA_AAAA, 32'h7FFF_FFFF);
    send_item(32'd2, 63'd32, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 63'd2, 32'hFFFF_FFFD);
    drain_results();

    // Long receiver hold-off while items keep coming
    rx_hold_req <= 1'b1;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 8);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        // Modulus: full range, small, tiny, near the top, or around a power of two
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
          mod_v = $urandom;
        end else if (roll < 60) begin
          mod_v = $urandom_range(1, 1000);
        end else if (roll < 70) begin
          mod_v = $urandom_range(1, 2);
        end else if (roll < 85) begin
          mod_v = 32'hFFFF_FFFF - $urandom_range(0, 64);
        end else begin
          mod_v = (32'd1 << $urandom_range(1, 31)) + $urandom_range(0, 2) - 1;
        end
        if (mod_v == '0) begin
          mod_v = 32'd1;
        end

        // Base: random, corners, the modulus or one below it, or a multiple of the modulus
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          base_v = $urandom;
        end else if (roll < 75) begin
          case ($urandom_range(0, 2))
            0:       base_v = 32'd0;
            1:       base_v = 32'd1;
            default: base_v = 32'hFFFF_FFFF;
          endcase
        end else if (roll < 90) begin
          base_v = mod_v - $urandom_range(0, 1);
        end else begin
          wide   = {32'd0, mod_v} * $urandom_range(1, 3);
          base_v = (wide > 64'hFFFF_FFFF) ? mod_v : wide[FIELD_W-1:0];
        end

        // Exponent: mostly short, a few full width, some zero or a lone set bit
        roll = $urandom_range(0, 99);
        wide = {$urandom, $urandom};
        if (roll < 70) begin
          nbits  = $urandom_range(1, 16);
          expo_v = wide[EXP_W-1:0] & ((63'd1 << nbits) - 63'd1);
          expo_v[nbits-1] = 1'b1;
        end else if (roll < 80) begin
          expo_v = '0;
        end else if (roll < 92) begin
          expo_v = wide[EXP_W-1:0];
        end else begin
          expo_v = 63'd1 << $urandom_range(0, EXP_W - 1);
        end

        send_item(base_v, expo_v, mod_v);
        sent++;
      end
      // Pause once midway until the block has emptied
      if (sent >= RANDOM_ITEMS / 2 && sent - burst < RANDOM_ITEMS / 2) begin
        drain_results();
      end else if ($urandom_range(0, 3) != 0) begin
        idle_gap($urandom_range(1, 12));
      end
    end

    // Wait for the last results, then a little longer for strays
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("** modular_exponentiation: PASSED **");
    end else begin
      $display("** modular_exponentiation: FAILED **");
    end
    $finish;
  end

endmodule
